// ===== src/fade_in_out_weight_envelope_assert.svh =====
// assertion macros for the fade envelope checker
// expects clk_i and rst_ni in the scope of use
`ifndef FADE_IN_OUT_WEIGHT_ENVELOPE_ASSERT_SVH
`define FADE_IN_OUT_WEIGHT_ENVELOPE_ASSERT_SVH

// same-cycle implication
`define FIOE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FIOE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fioe_pkg.sv =====
// shared types and constants of the fade envelope
// no dependencies
package fioe_pkg;

  localparam int LEN_W         = 24;
  localparam int TOTAL_W       = 26;
  localparam int DELTA_W       = 16;
  localparam int WEIGHT_W      = 16;
  localparam int POS_W         = 32;
  localparam int Q_FRAC        = 15;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [WEIGHT_W-1:0] ONE_Q15 = WEIGHT_W'(32768);

  localparam logic [1:0] PH_IN     = 2'd0;
  localparam logic [1:0] PH_STEADY = 2'd1;
  localparam logic [1:0] PH_OUT    = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [DELTA_W-1:0] delta;
    logic [LEN_W-1:0]   fade_in_len;
    logic [LEN_W-1:0]   fade_out_len;
  } fioe_in_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                active;
    logic [1:0]          phase;
    logic [POS_W-1:0]    play_position;
  } fioe_out_t;

endpackage

// ===== src/fioe_div.sv =====
// radix-2 restoring divider giving a saturated q1.15 ratio num/den
// depends on fioe_pkg
module fioe_div
  import fioe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TOTAL_W-1:0] num_i,
  input  logic [LEN_W-1:0]   den_i,
  output logic               done_o,
  output logic [WEIGHT_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(Q_FRAC);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic [LEN_W-1:0]    den_q, den_d;
  logic [WEIGHT_W-1:0] quot_q, quot_d;
  logic [LEN_W:0]      trial;
  logic [LEN_W:0]      diff;
  logic                fits;
  logic                sat;

  assign trial = {rem_q, 1'b0};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};
  assign sat   = num_i >= TOTAL_W'(den_i);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      den_d = den_i;
      if (sat) begin
        quot_d = ONE_Q15;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = num_i[LEN_W-1:0];
        quot_d = '0;
        cnt_d  = CNT_W'(Q_FRAC - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (fits) begin
        rem_d = diff[LEN_W-1:0];
      end else begin
        rem_d = trial[LEN_W-1:0];
      end
      quot_d = {quot_q[WEIGHT_W-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/fade_in_out_weight_envelope.sv =====
// linear fade-in / fade-out weight envelope, top level
// depends on fioe_pkg and fioe_div
//
// One transaction in gives one transaction out. A start transaction rewinds
// the clip and latches the fade lengths; its result is ready once it has
// passed the add state. A tick with no ratio to compute passes the add and
// evaluate states; a tick in a fade phase then runs the shared restoring
// divider, one quotient bit per cycle, which returns one outright if the ratio
// saturates. The block takes no new transaction until its result has been
// taken and it is idle again. clip_length may be written when idle.
module fade_in_out_weight_envelope
  import fioe_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fioe_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fioe_out_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i
);

  localparam int CMP_W = (TIME_BITS > TOTAL_W) ? TIME_BITS : TOTAL_W;
  localparam int PW    = (TIME_BITS > POS_W) ? TIME_BITS : POS_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RES  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  fioe_in_t             item_q;
  logic [LEN_W-1:0]     clip_q;
  logic [1:0]           phase_q, phase_d;
  logic [WEIGHT_W-1:0]  weight_q, weight_d;
  logic                 active_q, active_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0] pos_q, pos_d;
  logic [LEN_W-1:0]     fade_in_q, fade_in_d;
  logic [LEN_W-1:0]     fade_out_q, fade_out_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  logic [TIME_BITS:0]   elapsed_sum;
  logic [TIME_BITS:0]   pos_sum;
  logic [TIME_BITS-1:0] elapsed_sat;
  logic [TIME_BITS-1:0] pos_sat;
  logic [CMP_W-1:0]     e_c;
  logic [CMP_W-1:0]     total_c;
  logic [CMP_W-1:0]     steady_end_c;
  logic [CMP_W-1:0]     rest_c;

  logic [1:0]           ev_phase;
  logic [WEIGHT_W-1:0]  ev_weight;
  logic                 ev_active;
  logic [TIME_BITS-1:0] ev_pos;
  logic                 ev_div;
  logic [TOTAL_W-1:0]   ev_num;
  logic [LEN_W-1:0]     ev_den;

  logic                 div_start;
  logic                 div_done;
  logic [WEIGHT_W-1:0]  div_quot;
  logic [PW-1:0]        pos_w;

  assign elapsed_sum  = {1'b0, elapsed_q} + (TIME_BITS+1)'(item_q.delta);
  assign elapsed_sat  = elapsed_sum[TIME_BITS] ? '1 : elapsed_sum[TIME_BITS-1:0];
  assign pos_sum      = {1'b0, pos_q} + (TIME_BITS+1)'(item_q.delta);
  assign pos_sat      = pos_sum[TIME_BITS] ? '1 : pos_sum[TIME_BITS-1:0];
  assign e_c          = CMP_W'(elapsed_q);
  assign total_c      = CMP_W'(total_q);
  assign steady_end_c = CMP_W'(clip_q) + CMP_W'(fade_in_q);
  assign rest_c       = total_c - e_c;

  // phase walk of a tick on the updated elapsed time
  always_comb begin
    ev_phase  = phase_q;
    ev_weight = weight_q;
    ev_active = 1'b1;
    ev_pos    = pos_q;
    ev_div    = 1'b0;
    ev_num    = '0;
    ev_den    = '0;
    if (ev_phase == PH_IN) begin
      if (e_c < CMP_W'(fade_in_q)) begin
        ev_div = 1'b1;
        ev_num = TOTAL_W'(e_c);
        ev_den = fade_in_q;
      end else begin
        ev_phase  = PH_STEADY;
        ev_weight = ONE_Q15;
      end
    end
    if (ev_phase == PH_STEADY) begin
      ev_pos = pos_sat;
      if (e_c >= steady_end_c) begin
        ev_phase = PH_OUT;
      end
    end
    if (ev_phase == PH_OUT) begin
      if (e_c < total_c) begin
        ev_div = 1'b1;
        ev_num = TOTAL_W'(rest_c);
        ev_den = fade_out_q;
      end else begin
        ev_weight = '0;
        ev_active = 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    weight_d   = weight_q;
    active_d   = active_q;
    elapsed_d  = elapsed_q;
    pos_d      = pos_q;
    fade_in_d  = fade_in_q;
    fade_out_d = fade_out_q;
    total_d    = total_q;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (item_q.operation == OP_START) begin
          pos_d      = '0;
          elapsed_d  = '0;
          fade_in_d  = item_q.fade_in_len;
          fade_out_d = item_q.fade_out_len;
          total_d    = TOTAL_W'(clip_q) + TOTAL_W'(item_q.fade_in_len)
                       + TOTAL_W'(item_q.fade_out_len);
          phase_d    = PH_IN;
          active_d   = 1'b1;
          state_d    = ST_RES;
        end else begin
          elapsed_d = elapsed_sat;
          state_d   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        phase_d   = ev_phase;
        pos_d     = ev_pos;
        active_d  = ev_active;
        weight_d  = ev_weight;
        div_start = ev_div;
        state_d   = ev_div ? ST_DIV : ST_RES;
      end
      ST_DIV: begin
        if (div_done) begin
          weight_d = div_quot;
          state_d  = ST_RES;
        end
      end
      ST_RES: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      clip_q     <= '0;
      phase_q    <= PH_STEADY;
      weight_q   <= ONE_Q15;
      active_q   <= 1'b1;
      elapsed_q  <= '0;
      pos_q      <= '0;
      fade_in_q  <= '0;
      fade_out_q <= '0;
      total_q    <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      weight_q   <= weight_d;
      active_q   <= active_d;
      elapsed_q  <= elapsed_d;
      pos_q      <= pos_d;
      fade_in_q  <= fade_in_d;
      fade_out_q <= fade_out_d;
      total_q    <= total_d;
      if (cfg_valid_i) begin
        clip_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  fioe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ev_num),
    .den_i   (ev_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign pos_w = PW'(pos_q);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_RES);
  assign cfg_ready_o = 1'b1;

  assign out_data_o.weight        = weight_q;
  assign out_data_o.active        = active_q;
  assign out_data_o.phase         = phase_q;
  assign out_data_o.play_position = (pos_w > PW'({POS_W{1'b1}})) ? '1 : pos_w[POS_W-1:0];

endmodule

// ===== src/fioe_checker.sv =====
// port-level checker for the fade envelope, bound to the top level
// depends on fioe_pkg and fade_in_out_weight_envelope_assert.svh
`include "fade_in_out_weight_envelope_assert.svh"

module fioe_checker
  import fioe_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input fioe_out_t out_data_o
);

  `FIOE_ASSERT_NOW(a_no_accept_while_result, out_valid_o, in_stall_o, "input taken while result pending")

  `FIOE_ASSERT_NEXT(a_no_same_cycle_result, in_valid_i && !in_stall_o, !out_valid_o, "result without work cycle")

  `FIOE_ASSERT_NOW(a_weight_range, out_valid_o, out_data_o.weight <= ONE_Q15, "weight above one")

  `FIOE_ASSERT_NOW(a_finished_shape, out_valid_o && !out_data_o.active, out_data_o.weight == '0 && out_data_o.phase == PH_OUT, "finished envelope with weight or wrong phase")

  `FIOE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind fade_in_out_weight_envelope fioe_checker u_fioe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== sim/tb_fade_in_out_weight_envelope.sv =====
`timescale 1ns / 1ps
// testbench for the fade in/out weight envelope: directed and random start and tick
// transactions, each result checked against a cycle-free model of the envelope
// depends on fioe_pkg and fade_in_out_weight_envelope
module tb_fade_in_out_weight_envelope;
  import fioe_pkg::*;

  localparam longint unsigned TIME_MAX  = 64'h0000_0000_FFFF_FFFF;
  localparam int              IDLE_LIMIT = 2000;
  localparam int              SETTLE     = 25;
  localparam int              RAND_ITEMS = 1400;

  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  fioe_in_t         in_data   = '0;
  logic             out_stall = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [LEN_W-1:0] cfg_data  = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  fioe_out_t        out_data_o;
  logic             cfg_ready_o;

  fade_in_out_weight_envelope u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // envelope state as the block should hold it
  logic [LEN_W-1:0]    clip_len      = '0;
  logic [1:0]          env_phase     = PH_STEADY;
  longint unsigned     env_elapsed   = 0;
  longint unsigned     env_pos       = 0;
  longint unsigned     env_fade_in   = 0;
  longint unsigned     env_fade_out  = 0;
  longint unsigned     env_total     = 0;
  logic [WEIGHT_W-1:0] env_weight    = ONE_Q15;
  logic                env_active    = 1'b1;

  fioe_out_t expected_envelope_q[$];
  fioe_out_t want_res;
  int        mismatch_count = 0;
  int        items_sent     = 0;
  int        burst_left     = 0;
  int        idle_cycles    = 0;
  int        stall_pct      = 0;
  int        stall_left     = 0;

  function automatic longint unsigned sat_time(longint unsigned sum);
    return (sum > TIME_MAX) ? TIME_MAX : sum;
  endfunction

  function automatic logic [WEIGHT_W-1:0] q15_ratio(longint unsigned num,
                                                   longint unsigned den);
    longint unsigned q;
    if (den == 0) return ONE_Q15;
    q = (num << Q_FRAC) / den;
    return (q > longint'(ONE_Q15)) ? ONE_Q15 : q[WEIGHT_W-1:0];
  endfunction

  task automatic envelope_step(input fioe_in_t item, output fioe_out_t res);
    logic alive;
    alive = 1'b1;
    if (item.operation == OP_START) begin
      env_pos      = 0;
      env_fade_in  = item.fade_in_len;
      env_fade_out = item.fade_out_len;
      env_total    = longint'(clip_len) + env_fade_in + env_fade_out;
      env_elapsed  = 0;
      env_phase    = PH_IN;
    end else begin
      env_elapsed = sat_time(env_elapsed + item.delta);
      if (env_phase == PH_IN) begin
        if (env_elapsed < env_fade_in) begin
          env_weight = q15_ratio(env_elapsed, env_fade_in);
        end else begin
          env_phase  = PH_STEADY;
          env_weight = ONE_Q15;
        end
      end
      if (env_phase == PH_STEADY) begin
        env_pos = sat_time(env_pos + item.delta);
        if (env_elapsed >= longint'(clip_len) + env_fade_in) env_phase = PH_OUT;
      end
      if (env_phase == PH_OUT) begin
        if (env_elapsed < env_total) begin
          env_weight = q15_ratio(env_total - env_elapsed, env_fade_out);
        end else begin
          env_weight = '0;
          alive      = 1'b0;
        end
      end
    end
    res.weight        = env_weight;
    res.active        = alive;
    res.phase         = env_phase;
    res.play_position = (env_pos > 64'hFFFF_FFFF) ? '1 : env_pos[POS_W-1:0];
    env_active        = alive;
  endtask

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    if (mismatch_count < 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    mismatch_count++;
  endtask

  // one transaction in; the sender pauses for a random gap at the end of a burst
  task automatic send_item(input fioe_in_t item);
    fioe_out_t res;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall_o);
    envelope_step(item, res);
    expected_envelope_q.push_back(res);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_envelope();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    while (expected_envelope_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_clip_length(input logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    clip_len = value;
  endtask

  function automatic fioe_in_t make_item(input logic op, input int unsigned dly,
                                         input int unsigned fin, input int unsigned fout);
    fioe_in_t item;
    item.operation    = op;
    item.delta        = dly[DELTA_W-1:0];
    item.fade_in_len  = fin[LEN_W-1:0];
    item.fade_out_len = fout[LEN_W-1:0];
    return item;
  endfunction

  task automatic test_tick_before_start();
    send_item(make_item(OP_TICK, 0, $urandom, $urandom));
    send_item(make_item(OP_TICK, 16'hFFFF, $urandom, $urandom));
  endtask

  task automatic test_field_extremes();
    send_item(make_item(OP_START, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(OP_TICK, 16'hFFFF, 0, 0));
    send_item(make_item(OP_TICK, 0, 24'hFFFFFF, 24'hFFFFFF));
    drain_envelope();
    write_clip_length('1);
    send_item(make_item(OP_START, 0, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_item(OP_TICK, 16'hFFFF, 0, 0));
  endtask

  task automatic test_zero_fades();
    drain_envelope();
    write_clip_length(LEN_W'(16));
    send_item(make_item(OP_START, 0, 0, 40));
    send_item(make_item(OP_TICK, 0, 0, 0));
    send_item(make_item(OP_TICK, 10, 0, 0));
    send_item(make_item(OP_TICK, 10, 0, 0));
    send_item(make_item(OP_TICK, 40, 0, 0));
    send_item(make_item(OP_TICK, 1, 0, 0));
    send_item(make_item(OP_START, 0, 0, 0));
    send_item(make_item(OP_TICK, 16, 0, 0));
  endtask

  // clip shortened after start: zero fade-out and a fade-out ratio above one
  task automatic test_clip_lowered();
    drain_envelope();
    write_clip_length(LEN_W'(1000));
    send_item(make_item(OP_START, 0, 10, 0));
    drain_envelope();
    write_clip_length(LEN_W'(100));
    send_item(make_item(OP_TICK, 200, 0, 0));
    drain_envelope();
    write_clip_length(LEN_W'(1000));
    send_item(make_item(OP_START, 0, 10, 100));
    drain_envelope();
    write_clip_length(LEN_W'(100));
    send_item(make_item(OP_TICK, 200, 0, 0));
    send_item(make_item(OP_TICK, 900, 0, 0));
    send_item(make_item(OP_TICK, 5, 0, 0));
  endtask

  function automatic int unsigned random_fade_len();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick <= 5) return $urandom_range(0, 255);
    if (pick <= 8) return $urandom_range(0, 4095);
    return $urandom_range(0, 24'hFFFFFF);
  endfunction

  task automatic test_random_envelopes();
    int              stop_at;
    int              extra;
    int unsigned     dmax;
    int unsigned     dly;
    longint unsigned span;
    fioe_in_t        item;
    while (items_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        drain_envelope();
        case ($urandom_range(0, 5))
          0:       write_clip_length('0);
          1:       write_clip_length('1);
          2:       write_clip_length(LEN_W'($urandom_range(0, 255)));
          3:       write_clip_length(LEN_W'($urandom));
          default: write_clip_length(LEN_W'($urandom_range(0, 4095)));
        endcase
      end
      item = make_item(OP_START, $urandom, random_fade_len(), random_fade_len());
      send_item(item);
      span    = longint'(clip_len) + item.fade_in_len + item.fade_out_len;
      dmax    = (span / 6 + 1 > 65535) ? 65535 : int'(span / 6 + 1);
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 40;
      extra   = $urandom_range(0, 2);
      for (int t = 0; t < stop_at; t++) begin
        dly  = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, dmax);
        item = make_item(OP_TICK, dly, $urandom, $urandom);
        if ($urandom_range(0, 49) == 0) item.operation = OP_START;
        send_item(item);
        if (!env_active) begin
          if (extra == 0) break;
          extra--;
        end
      end
    end
  endtask

  // result check, receiver stall pattern and watchdog
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 25;
        3:       stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    if (out_valid_o && !out_stall) begin
      if (expected_envelope_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result transaction with none expected", $realtime);
        mismatch_count++;
      end else begin
        want_res = expected_envelope_q.pop_front();
        if (out_data_o.weight !== want_res.weight)
          report_mismatch("weight", want_res.weight, out_data_o.weight);
        if (out_data_o.active !== want_res.active)
          report_mismatch("active", want_res.active, out_data_o.active);
        if (out_data_o.phase !== want_res.phase)
          report_mismatch("phase", want_res.phase, out_data_o.phase);
        if (out_data_o.play_position !== want_res.play_position)
          report_mismatch("play_position", want_res.play_position,
                          out_data_o.play_position);
      end
    end

    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_tick_before_start();
    test_field_extremes();
    test_zero_fades();
    test_clip_lowered();
    test_random_envelopes();
    drain_envelope();
    if (expected_envelope_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_envelope_q.size());
      mismatch_count += expected_envelope_q.size();
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
